@@ hw/rtl/cspd_pkg.sv @@
// Shared constants, types and helpers of the serial packet deframer.
package cspd_pkg;

  localparam int WINDOW_BYTES  = 32;
  localparam int PAYLOAD_BYTES = 8;

  localparam int PTR_W = $clog2(WINDOW_BYTES);
  localparam int CNT_W = ($clog2(WINDOW_BYTES + 1) > 6) ? $clog2(WINDOW_BYTES + 1) : 6;

  localparam int ID_W       = 11;
  localparam int ID_FULL_W  = 32;
  localparam int PAYLOAD_W  = 64;
  localparam int PL_SEL_W   = 3;

  localparam logic [7:0] START_BYTE = 8'h5A;
  localparam logic [7:0] END_BYTE   = 8'hA5;
  localparam logic [7:0] STATUS_LEN = 8'hFE;
  localparam logic [7:0] MAX_DLEN   = 8'd8;

  localparam int STATUS_SIZE = 32;
  localparam int HEADER_SIZE = 7;
  localparam int CHAN_POS    = 2;
  localparam int LEN_POS     = 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_LEN_REQ,
    S_LEN_CHK,
    S_END_REQ,
    S_END_CHK,
    S_FLD_REQ,
    S_FLD_CHK,
    S_EMIT,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic             push;
    logic             drop;
    logic             clear;
    logic [CNT_W-1:0] drop_n;
  } win_cmd_t;

  typedef struct packed {
    logic emit;
    logic flush;
  } out_ctl_t;

  typedef struct packed {
    logic                 kind;
    logic [ID_W-1:0]      can_id;
    logic [PAYLOAD_W-1:0] payload;
  } result_t;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(n);
    if (sum >= (CNT_W + 1)'(WINDOW_BYTES)) begin
      sum = sum - (CNT_W + 1)'(WINDOW_BYTES);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ hw/rtl/cspd_window.sv @@
// Circular byte window: storage, head pointer and fill count.
module cspd_window (
  input  logic                     clk,
  input  logic                     rst,
  input  cspd_pkg::win_cmd_t       cmd,
  input  logic [7:0]               wr_data,
  input  logic [cspd_pkg::CNT_W-1:0] rd_idx,
  output logic [7:0]               rd_data,
  output logic [cspd_pkg::CNT_W-1:0] count
);

  logic [7:0]                 mem [cspd_pkg::WINDOW_BYTES];
  logic [cspd_pkg::PTR_W-1:0] head;
  logic [cspd_pkg::PTR_W-1:0] head_next;
  logic [cspd_pkg::CNT_W-1:0] count_next;
  logic [cspd_pkg::PTR_W-1:0] wr_addr;
  logic [cspd_pkg::PTR_W-1:0] rd_addr;
  logic                       full;

  assign full    = (count == cspd_pkg::CNT_W'(cspd_pkg::WINDOW_BYTES));
  assign wr_addr = full ? head : cspd_pkg::wrap_add(head, count);
  assign rd_addr = cspd_pkg::wrap_add(head, rd_idx);

  always_comb begin
    head_next  = head;
    count_next = count;
    if (cmd.push) begin
      if (full) begin
        head_next = cspd_pkg::wrap_add(head, cspd_pkg::CNT_W'(1));
      end else begin
        count_next = count + cspd_pkg::CNT_W'(1);
      end
    end else if (cmd.drop) begin
      head_next  = cspd_pkg::wrap_add(head, cmd.drop_n);
      count_next = count - cmd.drop_n;
    end else if (cmd.clear) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/cspd_seq.sv @@
// Scan sequencer: walks the window one byte read at a time and classifies packets.
module cspd_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rd_data,
  input  logic [cspd_pkg::CNT_W-1:0] count,
  output logic [cspd_pkg::CNT_W-1:0] rd_idx,
  output cspd_pkg::win_cmd_t         cmd,
  output cspd_pkg::out_ctl_t         ctl,
  input  logic                       out_ack,
  output cspd_pkg::result_t          res
);

  cspd_pkg::seq_state_t state, state_next;

  logic [cspd_pkg::CNT_W-1:0]     idx, idx_next;
  logic [cspd_pkg::CNT_W-1:0]     psize, psize_next;
  logic                           is_status, is_status_next;
  logic                           len_ok, len_ok_next;
  logic                           chan_bad, chan_bad_next;
  logic [cspd_pkg::ID_FULL_W-1:0] id, id_next;
  logic [cspd_pkg::PAYLOAD_W-1:0] payload, payload_next;
  logic                           res_kind, res_kind_next;

  logic                           scan_miss;
  logic                           is_start;
  logic                           too_short;
  logic                           len_status;
  logic                           len_big;
  logic                           status_short;
  logic [cspd_pkg::CNT_W-1:0]     data_psize;
  logic                           data_short;
  logic                           end_bad;
  logic                           fld_last;
  logic [cspd_pkg::CNT_W-1:0]     pl_off;

  always_comb begin
    scan_miss    = (idx >= count);
    is_start     = (rd_data == cspd_pkg::START_BYTE);
    too_short    = (count < cspd_pkg::CNT_W'(2));
    len_status   = (rd_data == cspd_pkg::STATUS_LEN);
    len_big      = (rd_data > cspd_pkg::MAX_DLEN);
    status_short = (count < cspd_pkg::CNT_W'(cspd_pkg::STATUS_SIZE));
    data_psize   = cspd_pkg::CNT_W'(rd_data[3:0]) + cspd_pkg::CNT_W'(8);
    data_short   = (count < data_psize);
    end_bad      = (rd_data != cspd_pkg::END_BYTE);
    fld_last     = (idx == psize - cspd_pkg::CNT_W'(2));
    pl_off       = idx - cspd_pkg::CNT_W'(cspd_pkg::HEADER_SIZE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cspd_pkg::S_IDLE:     if (in_valid) state_next = cspd_pkg::S_SCAN_REQ;
      cspd_pkg::S_SCAN_REQ: state_next = scan_miss ? cspd_pkg::S_FINISH : cspd_pkg::S_SCAN_CHK;
      cspd_pkg::S_SCAN_CHK: state_next = is_start ? cspd_pkg::S_LEN_REQ : cspd_pkg::S_SCAN_REQ;
      cspd_pkg::S_LEN_REQ:  state_next = too_short ? cspd_pkg::S_FINISH : cspd_pkg::S_LEN_CHK;
      cspd_pkg::S_LEN_CHK: begin
        if (len_status) begin
          state_next = status_short ? cspd_pkg::S_FINISH : cspd_pkg::S_END_REQ;
        end else if (len_big) begin
          state_next = cspd_pkg::S_EMIT;
        end else begin
          state_next = data_short ? cspd_pkg::S_FINISH : cspd_pkg::S_END_REQ;
        end
      end
      cspd_pkg::S_END_REQ:  state_next = cspd_pkg::S_END_CHK;
      cspd_pkg::S_END_CHK: begin
        if (end_bad) begin
          state_next = cspd_pkg::S_EMIT;
        end else if (is_status) begin
          state_next = cspd_pkg::S_SCAN_REQ;
        end else if (!len_ok) begin
          state_next = cspd_pkg::S_EMIT;
        end else begin
          state_next = cspd_pkg::S_FLD_REQ;
        end
      end
      cspd_pkg::S_FLD_REQ:  state_next = cspd_pkg::S_FLD_CHK;
      cspd_pkg::S_FLD_CHK:  state_next = fld_last ? cspd_pkg::S_EMIT : cspd_pkg::S_FLD_REQ;
      cspd_pkg::S_EMIT:     if (out_ack) state_next = cspd_pkg::S_SCAN_REQ;
      cspd_pkg::S_FINISH:   if (out_ack) state_next = cspd_pkg::S_IDLE;
      default:              state_next = cspd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    ctl            = '0;
    idx_next       = idx;
    psize_next     = psize;
    is_status_next = is_status;
    len_ok_next    = len_ok;
    chan_bad_next  = chan_bad;
    id_next        = id;
    payload_next   = payload;
    res_kind_next  = res_kind;
    unique case (state)
      cspd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.push = in_valid;
        idx_next = '0;
      end
      cspd_pkg::S_SCAN_REQ: begin
        cmd.clear = scan_miss;
      end
      cspd_pkg::S_SCAN_CHK: begin
        if (is_start) begin
          cmd.drop   = 1'b1;
          cmd.drop_n = idx;
          idx_next   = cspd_pkg::CNT_W'(cspd_pkg::LEN_POS);
        end else begin
          idx_next = idx + cspd_pkg::CNT_W'(1);
        end
      end
      cspd_pkg::S_LEN_REQ: begin
        idx_next = cspd_pkg::CNT_W'(cspd_pkg::LEN_POS);
      end
      cspd_pkg::S_LEN_CHK: begin
        is_status_next = len_status;
        len_ok_next    = (rd_data == 8'(cspd_pkg::PAYLOAD_BYTES));
        if (len_status) begin
          psize_next = cspd_pkg::CNT_W'(cspd_pkg::STATUS_SIZE);
          idx_next   = cspd_pkg::CNT_W'(cspd_pkg::STATUS_SIZE - 1);
        end else if (len_big) begin
          cmd.drop      = 1'b1;
          cmd.drop_n    = cspd_pkg::CNT_W'(1);
          res_kind_next = 1'b1;
        end else begin
          psize_next = data_psize;
          idx_next   = data_psize - cspd_pkg::CNT_W'(1);
        end
      end
      cspd_pkg::S_END_REQ: ;
      cspd_pkg::S_END_CHK: begin
        idx_next = cspd_pkg::CNT_W'(cspd_pkg::CHAN_POS);
        if (end_bad) begin
          cmd.drop      = 1'b1;
          cmd.drop_n    = cspd_pkg::CNT_W'(1);
          res_kind_next = 1'b1;
        end else if (is_status) begin
          cmd.drop   = 1'b1;
          cmd.drop_n = psize;
          idx_next   = '0;
        end else if (!len_ok) begin
          cmd.drop      = 1'b1;
          cmd.drop_n    = psize;
          res_kind_next = 1'b1;
        end else begin
          chan_bad_next = 1'b0;
          id_next       = '0;
          payload_next  = '0;
        end
      end
      cspd_pkg::S_FLD_REQ: ;
      cspd_pkg::S_FLD_CHK: begin
        if (idx == cspd_pkg::CNT_W'(cspd_pkg::CHAN_POS)) begin
          chan_bad_next = (rd_data != 8'd0);
        end else if (idx < cspd_pkg::CNT_W'(cspd_pkg::HEADER_SIZE)) begin
          id_next = {id[cspd_pkg::ID_FULL_W-9:0], rd_data};
        end else begin
          payload_next[8*pl_off[cspd_pkg::PL_SEL_W-1:0] +: 8] = rd_data;
        end
        if (fld_last) begin
          cmd.drop      = 1'b1;
          cmd.drop_n    = psize;
          res_kind_next = chan_bad || (id[cspd_pkg::ID_FULL_W-1:cspd_pkg::ID_W] != '0);
        end else begin
          idx_next = idx + cspd_pkg::CNT_W'(1);
        end
      end
      cspd_pkg::S_EMIT: begin
        ctl.emit = 1'b1;
        idx_next = '0;
      end
      cspd_pkg::S_FINISH: begin
        ctl.flush = 1'b1;
      end
      default: ;
    endcase
  end

  assign rd_idx         = idx;
  assign res.kind       = res_kind;
  assign res.can_id     = res_kind ? '0 : id[cspd_pkg::ID_W-1:0];
  assign res.payload    = res_kind ? '0 : payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cspd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    psize     <= psize_next;
    is_status <= is_status_next;
    len_ok    <= len_ok_next;
    chan_bad  <= chan_bad_next;
    id        <= id_next;
    payload   <= payload_next;
    res_kind  <= res_kind_next;
  end

endmodule

@@ hw/rtl/cspd_out.sv @@
// Result holding stage and output register; marks the last result of each item.
module cspd_out (
  input  logic                           clk,
  input  logic                           rst,
  input  cspd_pkg::out_ctl_t             ctl,
  input  cspd_pkg::result_t              res,
  output logic                           ack,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           kind,
  output logic [cspd_pkg::ID_W-1:0]      can_id,
  output logic [cspd_pkg::PAYLOAD_W-1:0] payload,
  output logic                           last
);

  cspd_pkg::result_t pend;
  logic              pend_valid;
  logic              out_free;
  logic              move;

  assign out_free = !out_valid || out_ready;
  assign ack      = !pend_valid || out_free;
  assign move     = (ctl.emit || ctl.flush) && pend_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.emit && ack) begin
        pend_valid <= 1'b1;
      end else if (ctl.flush && ack) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      kind    <= pend.kind;
      can_id  <= pend.can_id;
      payload <= pend.payload;
      last    <= ctl.flush;
    end
    if (ctl.emit && ack) begin
      pend <= res;
    end
  end

endmodule

@@ hw/rtl/can_serial_packet_deframer.sv @@
// Top level of the CAN-over-serial packet deframer.
// Takes one received byte per item into a 32-byte circular window and rescans the
// window for 0x5A-framed packets, giving zero or more results per byte (a decoded
// standard frame, or an invalid event), the final one flagged by last. One shared
// window read port serves the whole scan, each byte read taking a request state
// and a check state, so the scan of an item grows with the window bytes examined,
// and a resync rescans the window from its head after each rejected start byte.
// in_ready is high only while the sequencer is idle; results wait in an output
// register, and the scan stalls while that register and its holding stage are
// both occupied.
module can_serial_packet_deframer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           kind,
  output logic [cspd_pkg::ID_W-1:0]      can_id,
  output logic [cspd_pkg::PAYLOAD_W-1:0] payload,
  output logic                           last
);

  cspd_pkg::win_cmd_t         cmd;
  cspd_pkg::out_ctl_t         ctl;
  cspd_pkg::result_t          res;
  logic [7:0]                 rd_data;
  logic [cspd_pkg::CNT_W-1:0] count;
  logic [cspd_pkg::CNT_W-1:0] rd_idx;
  logic                       out_ack;

  cspd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .wr_data (rx_byte),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .count   (count)
  );

  cspd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rd_data  (rd_data),
    .count    (count),
    .rd_idx   (rd_idx),
    .cmd      (cmd),
    .ctl      (ctl),
    .out_ack  (out_ack),
    .res      (res)
  );

  cspd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .res       (res),
    .ack       (out_ack),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .can_id    (can_id),
    .payload   (payload),
    .last      (last)
  );

endmodule

@@ hw/rtl/cspd_checker.sv @@
// Port-level checks of the deframer, bound to the top level.
module cspd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           kind,
  input logic [cspd_pkg::ID_W-1:0]      can_id,
  input logic [cspd_pkg::PAYLOAD_W-1:0] payload,
  input logic                           last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> can_id == '0 && payload == '0)
    else $error("invalid event carries nonzero fields");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while previous one is being scanned");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload) && $stable(last))
    else $error("stalled result changed");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind can_serial_packet_deframer cspd_checker u_cspd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .can_id    (can_id),
  .payload   (payload),
  .last      (last)
);
